### hw/rtl/chacha_pkg.sv
// ChaCha20 cipher package: constants, types and the quarter-round helper.
package chacha_pkg;
	localparam int DefaultRoundCount = 20;
	localparam logic [31:0] Sigma0 = 32'h61707865;
	localparam logic [31:0] Sigma1 = 32'h3320646e;
	localparam logic [31:0] Sigma2 = 32'h79622d32;
	localparam logic [31:0] Sigma3 = 32'h6b206574;

	localparam logic [2:0] RegKey01 = 3'd0;
	localparam logic [2:0] RegKey23 = 3'd1;
	localparam logic [2:0] RegKey45 = 3'd2;
	localparam logic [2:0] RegKey67 = 3'd3;
	localparam logic [2:0] RegNonce01 = 3'd4;
	localparam logic [2:0] RegNonce2 = 3'd5;
	localparam logic [2:0] RegCounter = 3'd6;

	typedef logic [31:0] word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_ROUND,
		ST_FINAL,
		ST_EMIT
	} state_t;

	typedef enum logic [2:0] {
		CS_IDLE,
		CS_LOAD,
		CS_READ,
		CS_HALF,
		CS_WRITE,
		CS_FINAL
	} core_state_t;

	typedef struct packed {
		word_t a;
		word_t b;
		word_t c;
		word_t d;
	} quad_t;

	function automatic word_t rotl(input word_t v, input int n);
		rotl = (v << n) | (v >> (32 - n));
	endfunction

	// half of a quarter round: two add/xor/rotate steps
	function automatic quad_t qhalf(input quad_t q, input int r1, input int r2);
		quad_t r;
		r = q;
		r.a = r.a + r.b; r.d = rotl(r.d ^ r.a, r1);
		r.c = r.c + r.d; r.b = rotl(r.b ^ r.c, r2);
		qhalf = r;
	endfunction
endpackage

### hw/rtl/chacha_stream_if.sv
// Valid/ready channel interfaces for the byte streams.
interface chacha_in_if;
	logic valid;
	logic ready;
	logic [7:0] plain_byte;
	logic message_start;
	logic message_end;
	modport source(output valid, plain_byte, message_start, message_end, input ready);
	modport sink(input valid, plain_byte, message_start, message_end, output ready);
endinterface

interface chacha_out_if;
	logic valid;
	logic ready;
	logic [7:0] cipher_byte;
	logic end_of_message;
	modport source(output valid, cipher_byte, end_of_message, input ready);
	modport sink(input valid, cipher_byte, end_of_message, output ready);
endinterface

### hw/rtl/chacha_core.sv
// Block function: working words in a 16-entry memory, one quarter round per visit.
module chacha_core import chacha_pkg::*; #(
	parameter int ROUND_COUNT = DefaultRoundCount
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  word_t [15:0] init,
	output logic done,
	output logic [3:0] ks_waddr,
	output word_t ks_wdata,
	output logic ks_we
);
	localparam int Doubles = (ROUND_COUNT + 1) / 2;
	localparam int QrTotal = Doubles * 8;
	localparam int QrW = $clog2(QrTotal + 1);

	// Working store: four banks (row = column index) so one quarter round
	// reads its four words in the same cycle.
	word_t mem_a [4];
	word_t mem_b [4];
	word_t mem_c [4];
	word_t mem_d [4];

	core_state_t st_q, st_d;
	logic [QrW-1:0] qr_q;
	logic [4:0] idx_q;
	quad_t rd_q;

	logic diag;
	logic [1:0] col;
	logic [1:0] ia, ib, ic, id;
	logic last_qr;
	assign diag = qr_q[2];
	assign col = qr_q[1:0];
	assign ia = col;
	assign ib = diag ? col + 2'd1 : col;
	assign ic = diag ? col + 2'd2 : col;
	assign id = diag ? col + 2'd3 : col;
	assign last_qr = (qr_q == QrW'(QrTotal - 1));

	// quarter round in two halves: first half into rd_q, second half to memory
	quad_t res;
	assign res = qhalf(rd_q, 8, 7);

	// final add: word idx = row*4+col; reads bank row at col
	logic [1:0] frow, fcol;
	assign frow = idx_q[3:2];
	assign fcol = idx_q[1:0];
	word_t fin_rd_q;
	logic fin_v_q;
	logic [3:0] fin_idx_q;

	always_ff @(posedge clk) begin
		case (st_q)
			CS_LOAD: begin
				mem_a[idx_q[1:0]] <= init[{2'd0, idx_q[1:0]}];
				mem_b[idx_q[1:0]] <= init[{2'd1, idx_q[1:0]}];
				mem_c[idx_q[1:0]] <= init[{2'd2, idx_q[1:0]}];
				mem_d[idx_q[1:0]] <= init[{2'd3, idx_q[1:0]}];
			end
			CS_READ: begin
				rd_q.a <= mem_a[ia];
				rd_q.b <= mem_b[ib];
				rd_q.c <= mem_c[ic];
				rd_q.d <= mem_d[id];
			end
			CS_HALF: rd_q <= qhalf(rd_q, 16, 12);
			CS_WRITE: begin
				mem_a[ia] <= res.a;
				mem_b[ib] <= res.b;
				mem_c[ic] <= res.c;
				mem_d[id] <= res.d;
			end
			default: ;
		endcase
		case (frow)
			2'd0: fin_rd_q <= mem_a[fcol];
			2'd1: fin_rd_q <= mem_b[fcol];
			2'd2: fin_rd_q <= mem_c[fcol];
			default: fin_rd_q <= mem_d[fcol];
		endcase
		fin_idx_q <= idx_q[3:0];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			CS_IDLE: if (start) st_d = CS_LOAD;
			CS_LOAD: if (idx_q[1:0] == 2'd3) st_d = CS_READ;
			CS_READ: st_d = CS_HALF;
			CS_HALF: st_d = CS_WRITE;
			CS_WRITE: begin
				if (last_qr) st_d = CS_FINAL;
				else st_d = CS_READ;
			end
			CS_FINAL: if (idx_q[4]) st_d = CS_IDLE;
			default: st_d = CS_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CS_IDLE;
			qr_q <= '0;
			idx_q <= '0;
			fin_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			fin_v_q <= (st_q == CS_FINAL) && !idx_q[4];
			case (st_q)
				CS_IDLE: idx_q <= '0;
				CS_LOAD: begin
					idx_q <= idx_q + 5'd1;
					qr_q <= '0;
				end
				CS_WRITE: begin
					if (last_qr) idx_q <= '0;
					else qr_q <= qr_q + QrW'(1);
				end
				CS_FINAL: if (!idx_q[4]) idx_q <= idx_q + 5'd1;
				default: ;
			endcase
		end
	end

	assign ks_we = fin_v_q;
	assign ks_waddr = fin_idx_q;
	assign ks_wdata = fin_rd_q + init[fin_idx_q];
	assign done = (st_q == CS_FINAL) && idx_q[4];
endmodule

### hw/rtl/chacha20_stream_cipher.sv
// ChaCha20 byte stream cipher top level.
// Usage: write key, nonce and initial counter through cfg_we/cfg_index/cfg_data
// while idle (indexes 0..6 as listed; others ignored). Plaintext bytes enter on
// channel in (valid/ready) with message_start/message_end flags; each byte
// leaves on channel out as cipher_byte with end_of_message copied.
// A byte that needs a fresh 64-byte block (first of a block, or message start)
// waits for the block function: start, load of the working words, a read, half
// and write step for each of 8*ceil(ROUND_COUNT/2) quarter rounds, and the final
// add into the keystream memory; then come the keystream read and the result
// register. Other bytes go straight to the keystream read and result register.
// One byte is in work at a time. A stalled receiver holds the result register;
// the following transaction is still accepted, then waits until the result
// drains, and input stops meanwhile. Reset clears counter, byte position,
// configuration and control; the keystream memory holds no valid data until
// the first block is made.
module chacha20_stream_cipher import chacha_pkg::*; #(
	parameter int ROUND_COUNT = DefaultRoundCount
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data,
	chacha_in_if.sink in,
	chacha_out_if.source out
);
	logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce01_q;
	word_t nonce2_q, init_ctr_q, ctr_q;
	logic [5:0] pos_q;
	state_t st_q;
	logic [7:0] pb_q;
	logic end_q;
	word_t ks_mem [16];
	word_t ks_rd_q;
	logic [1:0] lane_q;
	logic out_v_q;
	logic [7:0] out_b_q;
	logic out_e_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q <= '0; key23_q <= '0; key45_q <= '0; key67_q <= '0;
			nonce01_q <= '0; nonce2_q <= '0; init_ctr_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				RegKey01: key01_q <= cfg_data;
				RegKey23: key23_q <= cfg_data;
				RegKey45: key45_q <= cfg_data;
				RegKey67: key67_q <= cfg_data;
				RegNonce01: nonce01_q <= cfg_data;
				RegNonce2: nonce2_q <= cfg_data[31:0];
				RegCounter: init_ctr_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	word_t [15:0] init;
	always_comb begin
		init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
		init[4] = key01_q[31:0]; init[5] = key01_q[63:32];
		init[6] = key23_q[31:0]; init[7] = key23_q[63:32];
		init[8] = key45_q[31:0]; init[9] = key45_q[63:32];
		init[10] = key67_q[31:0]; init[11] = key67_q[63:32];
		init[12] = ctr_q;
		init[13] = nonce01_q[31:0]; init[14] = nonce01_q[63:32];
		init[15] = nonce2_q;
	end

	logic core_start, core_done, ks_we;
	logic [3:0] ks_waddr;
	word_t ks_wdata;

	chacha_core #(.ROUND_COUNT(ROUND_COUNT)) u_core (
		.clk, .arst_n, .start(core_start), .init, .done(core_done),
		.ks_waddr, .ks_wdata, .ks_we
	);

	logic out_free, take;
	assign out_free = !out_v_q || out.ready;
	assign in.ready = (st_q == ST_IDLE);
	assign take = in.valid && in.ready;

	state_t st_d;
	logic rd_en;
	always_comb begin
		st_d = st_q;
		core_start = 1'b0;
		rd_en = 1'b0;
		case (st_q)
			ST_IDLE: if (take) begin
				if (in.message_start || pos_q == 6'd0) st_d = ST_LOAD;
				else st_d = ST_FINAL;
			end
			ST_LOAD: begin
				core_start = 1'b1;
				st_d = ST_ROUND;
			end
			ST_ROUND: if (core_done) st_d = ST_FINAL;
			ST_FINAL: begin
				rd_en = 1'b1;
				st_d = ST_EMIT;
			end
			ST_EMIT: if (out_free) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ks_we) ks_mem[ks_waddr] <= ks_wdata;
		if (rd_en) ks_rd_q <= ks_mem[pos_q[5:2]];
		if (take) begin
			pb_q <= in.plain_byte;
			end_q <= in.message_end;
		end
		if (rd_en) lane_q <= pos_q[1:0];
	end

	logic [7:0] ks_byte;
	always_comb begin
		case (lane_q)
			2'd0: ks_byte = ks_rd_q[7:0];
			2'd1: ks_byte = ks_rd_q[15:8];
			2'd2: ks_byte = ks_rd_q[23:16];
			default: ks_byte = ks_rd_q[31:24];
		endcase
	end

	logic emit;
	assign emit = (st_q == ST_EMIT) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ctr_q <= '0;
			pos_q <= '0;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (take && in.message_start) begin
				ctr_q <= init_ctr_q;
				pos_q <= '0;
			end
			if (emit) begin
				if (pos_q == 6'd63 || end_q) begin
					pos_q <= '0;
					ctr_q <= ctr_q + 32'd1;
				end else begin
					pos_q <= pos_q + 6'd1;
				end
			end
			if (emit) out_v_q <= 1'b1;
			else if (out.ready) out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_b_q <= pb_q ^ ks_byte;
			out_e_q <= end_q;
		end
	end

	assign out.valid = out_v_q;
	assign out.cipher_byte = out_b_q;
	assign out.end_of_message = out_e_q;
endmodule

### tb/sv/chacha20_stream_checker.sv
// Scoreboard for the ChaCha20 byte stream cipher: keystream predictor and output compare.
`timescale 1ns / 1ps
module chacha20_stream_checker import chacha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [63:0] cfg_data,
	input  logic in_valid,
	input  logic in_ready,
	input  logic [7:0] in_plain_byte,
	input  logic in_message_start,
	input  logic in_message_end,
	input  logic out_valid,
	input  logic out_ready,
	input  logic [7:0] out_cipher_byte,
	input  logic out_end_of_message,
	output int fail_count,
	output int pending_bytes
);
	typedef struct packed {
		logic [7:0] cipher_byte;
		logic end_of_message;
	} cipher_item_t;

	word_t key_w [8];
	word_t nonce_w [3];
	word_t start_counter;
	word_t block_counter;
	logic [5:0] byte_pos;
	word_t keystream [16];
	cipher_item_t cipher_q [$];

	function automatic word_t rot_left(input word_t v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	task automatic mix(inout word_t w [16], input int a, input int b, input int c, input int d);
		w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 16);
		w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 12);
		w[a] = w[a] + w[b]; w[d] = rot_left(w[d] ^ w[a], 8);
		w[c] = w[c] + w[d]; w[b] = rot_left(w[b] ^ w[c], 7);
	endtask

	task automatic build_keystream_block();
		word_t init [16];
		word_t w [16];
		init[0] = Sigma0; init[1] = Sigma1; init[2] = Sigma2; init[3] = Sigma3;
		for (int i = 0; i < 8; i++) init[4 + i] = key_w[i];
		init[12] = block_counter;
		for (int i = 0; i < 3; i++) init[13 + i] = nonce_w[i];
		w = init;
		for (int r = 0; r < DefaultRoundCount; r += 2) begin
			mix(w, 0, 4, 8, 12); mix(w, 1, 5, 9, 13);
			mix(w, 2, 6, 10, 14); mix(w, 3, 7, 11, 15);
			mix(w, 0, 5, 10, 15); mix(w, 1, 6, 11, 12);
			mix(w, 2, 7, 8, 13); mix(w, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++) keystream[i] = w[i] + init[i];
	endtask

	task automatic encrypt_byte(input logic [7:0] pb, input logic first, input logic last);
		cipher_item_t item;
		logic [7:0] ks;
		if (first) begin
			block_counter = start_counter;
			byte_pos = '0;
		end
		if (byte_pos == 0) build_keystream_block();
		ks = 8'(keystream[byte_pos[5:2]] >> (8 * byte_pos[1:0]));
		item.cipher_byte = pb ^ ks;
		item.end_of_message = last;
		cipher_q.push_back(item);
		byte_pos = byte_pos + 6'd1;
		if (byte_pos == 0) begin
			block_counter = block_counter + 32'd1;
		end else if (last) begin
			block_counter = block_counter + 32'd1;
			byte_pos = '0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		cipher_item_t exp_item;
		if (!arst_n) begin
			foreach (key_w[i]) key_w[i] = '0;
			foreach (nonce_w[i]) nonce_w[i] = '0;
			start_counter = '0;
			block_counter = '0;
			byte_pos = '0;
			fail_count = 0;
			cipher_q.delete();
			pending_bytes = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					RegKey01: begin key_w[0] = cfg_data[31:0]; key_w[1] = cfg_data[63:32]; end
					RegKey23: begin key_w[2] = cfg_data[31:0]; key_w[3] = cfg_data[63:32]; end
					RegKey45: begin key_w[4] = cfg_data[31:0]; key_w[5] = cfg_data[63:32]; end
					RegKey67: begin key_w[6] = cfg_data[31:0]; key_w[7] = cfg_data[63:32]; end
					RegNonce01: begin nonce_w[0] = cfg_data[31:0]; nonce_w[1] = cfg_data[63:32]; end
					RegNonce2: nonce_w[2] = cfg_data[31:0];
					RegCounter: start_counter = cfg_data[31:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				encrypt_byte(in_plain_byte, in_message_start, in_message_end);
			if (out_valid && out_ready) begin
				if (cipher_q.size() == 0) begin
					$display("%0t: unexpected output byte: expected none, actual %h/%b", $time,
						out_cipher_byte, out_end_of_message);
					fail_count++;
				end else begin
					exp_item = cipher_q.pop_front();
					if (out_cipher_byte !== exp_item.cipher_byte) begin
						$display("%0t: cipher_byte mismatch: expected %h, actual %h", $time,
							exp_item.cipher_byte, out_cipher_byte);
						fail_count++;
					end
					if (out_end_of_message !== exp_item.end_of_message) begin
						$display("%0t: end_of_message mismatch: expected %b, actual %b", $time,
							exp_item.end_of_message, out_end_of_message);
						fail_count++;
					end
				end
			end
			pending_bytes = cipher_q.size();
		end
	end
endmodule

### tb/sv/tb_chacha20_stream_cipher.sv
// Top level testbench for the ChaCha20 byte stream cipher: stimulus and verdict.
`timescale 1ns / 1ps
module tb_chacha20_stream_cipher;
	import chacha_pkg::*;

	localparam int WatchdogLimit = 5000;
	localparam int RandomBytes = 1800;
	localparam logic [2:0] RegUnused = 3'd7;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [63:0] cfg_data;
	int fail_count;
	int pending_bytes;
	int idle_cycles;
	bit calm_phase;
	bit rx_stall;

	chacha_in_if in_ch();
	chacha_out_if out_ch();

	chacha20_stream_cipher DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .in(in_ch), .out(out_ch)
	);

	chacha20_stream_checker checker_i (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_plain_byte(in_ch.plain_byte),
		.in_message_start(in_ch.message_start), .in_message_end(in_ch.message_end),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.out_cipher_byte(out_ch.cipher_byte), .out_end_of_message(out_ch.end_of_message),
		.fail_count(fail_count), .pending_bytes(pending_bytes)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// receiver stalls in random bursts, none during the calm phase
	initial begin
		int burst;
		out_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (burst > 0) begin
				burst--;
				if (burst == 0) out_ch.ready = 1'b1;
			end else if (!calm_phase && rx_stall && $urandom_range(0, 7) == 0) begin
				burst = $urandom_range(1, 16);
				out_ch.ready = 1'b0;
			end else begin
				out_ch.ready = 1'b1;
			end
		end
	end

	// watchdog: cycles with no transaction on either channel
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else if (arst_n) begin
			idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WatchdogLimit) begin
				$display("chacha20_stream_cipher verification failed");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic send_byte(input logic [7:0] pb, input logic first, input logic last);
		int gap;
		if (!calm_phase && $urandom_range(0, 9) == 0) begin
			in_ch.valid = 1'b0;
			gap = $urandom_range(1, 16);
			repeat (gap) @(negedge clk);
		end
		in_ch.valid = 1'b1;
		in_ch.plain_byte = pb;
		in_ch.message_start = first;
		in_ch.message_end = last;
		@(posedge clk);
		while (!in_ch.ready) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic drain();
		in_ch.valid = 1'b0;
		while (pending_bytes != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic send_message(input int len, input bit with_start, input bit with_end);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom_range(0, 255)), with_start && i == 0, with_end && i == len - 1);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	task automatic load_random_config();
		write_reg(RegKey01, rand64());
		write_reg(RegKey23, rand64());
		write_reg(RegKey45, rand64());
		write_reg(RegKey67, rand64());
		write_reg(RegNonce01, rand64());
		write_reg(RegNonce2, {32'h0, $urandom});
		case ($urandom_range(0, 3))
			0: write_reg(RegCounter, 64'hffff_ffff);
			1: write_reg(RegCounter, 64'hffff_fffe);
			default: write_reg(RegCounter, {32'h0, $urandom});
		endcase
	endtask

	initial begin
		int sent;
		int len;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_ch.valid = 1'b0;
		in_ch.plain_byte = '0;
		in_ch.message_start = 1'b0;
		in_ch.message_end = 1'b0;
		calm_phase = 1'b0;
		rx_stall = 1'b1;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: bytes with no start after reset run on counter 0 with zero key
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'ha5, 1'b0, 1'b1);
		// one-byte message, then a message crossing a block boundary
		send_byte(8'h5a, 1'b1, 1'b1);
		drain();
		write_reg(RegKey01, 64'hffff_ffff_ffff_ffff);
		write_reg(RegKey23, 64'hffff_ffff_ffff_ffff);
		write_reg(RegKey45, 64'hffff_ffff_ffff_ffff);
		write_reg(RegKey67, 64'hffff_ffff_ffff_ffff);
		write_reg(RegNonce01, 64'hffff_ffff_ffff_ffff);
		write_reg(RegNonce2, 64'hffff_ffff);
		write_reg(RegCounter, 64'hffff_ffff);
		// counter wraps from all ones to zero across the second block
		send_message(70, 1'b1, 1'b0);
		send_byte(8'hff, 1'b0, 1'b1);
		send_byte(8'h00, 1'b1, 1'b0);
		send_byte(8'h01, 1'b1, 1'b1);
		drain();
		// out-of-range register index is ignored
		write_reg(RegUnused, rand64());

		sent = 0;
		while (sent < RandomBytes) begin
			if (sent > RandomBytes - 200) calm_phase = 1'b1;
			if ($urandom_range(0, 3) == 0) begin
				drain();
				load_random_config();
			end
			case ($urandom_range(0, 9))
				0: len = 1;
				1: len = $urandom_range(60, 140);
				default: len = $urandom_range(2, 70);
			endcase
			// mostly well-formed messages, some missing start or end flags
			send_message(len, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
			sent += len;
		end
		drain();

		if (fail_count == 0)
			$display("chacha20_stream_cipher verification clean");
		else
			$display("chacha20_stream_cipher verification failed");
		$finish;
	end
endmodule

### sim.f
hw/rtl/chacha_pkg.sv
hw/rtl/chacha_stream_if.sv
hw/rtl/chacha_core.sv
hw/rtl/chacha20_stream_cipher.sv
tb/sv/chacha20_stream_checker.sv
tb/sv/tb_chacha20_stream_cipher.sv
